// ===== hw/rtl/ext80_pkg.sv =====
package ext80_pkg;

   localparam int MANT_W      = 64;
   localparam int EXP_W       = 15;
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = MANT_W / CHUNK_W;
   localparam int CLZ_W       = $clog2(CHUNK_W) + 1;
   localparam int LZ_W        = $clog2(MANT_W);
   localparam int SEXP_W      = 18;

   localparam logic [EXP_W-1:0]  EXP_SPECIAL = 15'h7FFF;
   localparam logic [63:0]       DBL_INF     = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0]       DBL_QNAN    = 64'h7FF8_0000_0000_0000;
   localparam logic [31:0]       U32_MAX     = 32'hFFFF_FFFF;

   // big exponent = biased_exponent - BIG_OFFSET - lz + carry
   localparam int BIG_OFFSET   = 16383;
   localparam int DBL_BIAS     = 1023;
   localparam int DBL_EMIN     = -1022;
   localparam int DBL_EMAX     = 1023;
   localparam int SUB_MAX_SH   = 54;

   typedef enum logic [2:0] {
      KIND_ZERO = 3'b001,
      KIND_FIXED = 3'b010,
      KIND_NUM  = 3'b100
   } kind_type;

endpackage

// ===== hw/rtl/ext80_clz16.sv =====
module ext80_clz16
   import ext80_pkg::*;
(
   input  logic [CHUNK_W-1:0] value,
   output logic [CLZ_W-1:0]   count
);

   // count leading zeros, full width when the chunk is empty
   always_comb begin
      count = CLZ_W'(CHUNK_W);
      for (int i = 0; i < CHUNK_W; i++) begin
         if (value[i]) begin
            count = CLZ_W'(CHUNK_W - 1 - i);
         end
      end
   end

endmodule

// ===== hw/rtl/extended80_to_double_and_uint.sv =====
// Channel  | Direction | Ports
// ---------+-----------+-------------------------------------------------------
// request  | in        | req_valid, req_stall, req_sign_bit, req_biased_exponent,
//          |           | req_mantissa
// response | out       | rsp_valid, rsp_stall, rsp_double_bits, rsp_rounded_unsigned
//
// Five register stages: chunk zero count, normalise, round to 53 bits,
// subnormal shift and pack, integer rounding. One request per cycle while
// the response is not stalled.
// Reset clears the stage valid bits only. A stalled response holds its stage;
// bubbles ahead of it are filled, so req_stall rises only when all stages are full.
module extended80_to_double_and_uint
   import ext80_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_sign_bit,
   input  logic [EXP_W-1:0]    req_biased_exponent,
   input  logic [MANT_W-1:0]   req_mantissa,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_double_bits,
   output logic [31:0]         rsp_rounded_unsigned
);

   // stage load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: per-chunk leading zero counts
   logic [CLZ_W-1:0] clz_in [CHUNKS];
   logic [CLZ_W-1:0] clz1_ff [CHUNKS];
   logic             s1_sign_ff;
   logic [EXP_W-1:0] s1_exp_ff;
   logic [MANT_W-1:0] s1_mant_ff;

   for (genvar g = 0; g < CHUNKS; g++) begin : g_clz
      ext80_clz16 u_clz (
         .value (req_mantissa[g*CHUNK_W +: CHUNK_W]),
         .count (clz_in[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sign_ff <= req_sign_bit;
         s1_exp_ff  <= req_biased_exponent;
         s1_mant_ff <= req_mantissa;
         for (int i = 0; i < CHUNKS; i++) clz1_ff[i] <= clz_in[i];
      end
   end

   // stage 2: combine counts and normalise
   logic [LZ_W-1:0]   lz_in;
   logic              mzero_in;
   logic [LZ_W-1:0]   s2_lz_ff;
   logic              s2_mzero_ff, s2_sign_ff;
   logic [EXP_W-1:0]  s2_exp_ff;
   logic [MANT_W-1:0] s2_mn_ff;

   always_comb begin
      lz_in    = '0;
      mzero_in = 1'b1;
      for (int i = 0; i < CHUNKS; i++) begin
         if (clz1_ff[i] != CLZ_W'(CHUNK_W)) begin
            lz_in    = LZ_W'((CHUNKS - 1 - i) * CHUNK_W) + LZ_W'(clz1_ff[i]);
            mzero_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_lz_ff    <= lz_in;
         s2_mzero_ff <= mzero_in;
         s2_sign_ff  <= s1_sign_ff;
         s2_exp_ff   <= s1_exp_ff;
         s2_mn_ff    <= s1_mant_ff << lz_in;
      end
   end

   // stage 3: round to 53 bits, work out exponents, classify
   logic [52:0]        m0;
   logic               up;
   logic [53:0]        msum;
   logic [52:0]        m_in;
   logic               carry;
   logic signed [SEXP_W-1:0] bige_in;
   kind_type           kind_in;
   logic [63:0]        fixed_in;
   logic [52:0]        s3_m_ff;
   logic signed [SEXP_W-1:0] s3_bige_ff;
   kind_type           s3_kind_ff;
   logic [63:0]        s3_fixed_ff;
   logic               s3_sign_ff;

   always_comb begin
      m0    = s2_mn_ff[63:11];
      up    = s2_mn_ff[10] && ((|s2_mn_ff[9:0]) || m0[0]);
      msum  = {1'b0, m0} + 54'(up);
      carry = msum[53];
      m_in  = carry ? msum[53:1] : msum[52:0];
      bige_in = SEXP_W'($signed({1'b0, s2_exp_ff})) - SEXP_W'(BIG_OFFSET)
              - SEXP_W'($signed({1'b0, s2_lz_ff})) + SEXP_W'($signed({1'b0, carry}));
      fixed_in = '0;
      kind_in  = KIND_NUM;
      if (s2_exp_ff == '0 && s2_mzero_ff) begin
         kind_in = KIND_ZERO;
      end else if (s2_exp_ff == EXP_SPECIAL) begin
         kind_in  = KIND_FIXED;
         fixed_in = s2_mzero_ff ? ({s2_sign_ff, 63'd0} | DBL_INF) : DBL_QNAN;
      end else if (s2_mzero_ff) begin
         kind_in  = KIND_FIXED;
         fixed_in = {s2_sign_ff, 63'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_m_ff     <= m_in;
         s3_bige_ff  <= bige_in;
         s3_kind_ff  <= kind_in;
         s3_fixed_ff <= fixed_in;
         s3_sign_ff  <= s2_sign_ff;
      end
   end

   // stage 4: pack zero, special, normal, overflow or subnormal result
   logic signed [SEXP_W-1:0] sub_sh;
   logic [106:0]       wide;
   logic [52:0]        q;
   logic               q_up;
   logic [52:0]        q_r;
   logic [10:0]        efield;
   logic [63:0]        dbl_in;
   logic [63:0]        s4_dbl_ff;

   always_comb begin
      sub_sh = SEXP_W'(-1022) - s3_bige_ff;
      wide   = {s3_m_ff, 54'd0} >> sub_sh[6:0];
      q      = wide[106:54];
      q_up   = wide[53] && ((|wide[52:0]) || q[0]);
      q_r    = q + 53'(q_up);
      efield = 11'(s3_bige_ff + SEXP_W'(DBL_BIAS));
      unique case (s3_kind_ff)
         KIND_ZERO:  dbl_in = '0;
         KIND_FIXED: dbl_in = s3_fixed_ff;
         KIND_NUM: begin
            if (s3_bige_ff > SEXP_W'(DBL_EMAX)) begin
               dbl_in = {s3_sign_ff, 63'd0} | DBL_INF;
            end else if (s3_bige_ff >= SEXP_W'(DBL_EMIN)) begin
               dbl_in = {s3_sign_ff, efield, s3_m_ff[51:0]};
            end else if (sub_sh <= SEXP_W'(SUB_MAX_SH)) begin
               dbl_in = {s3_sign_ff, 10'd0, q_r};
            end else begin
               dbl_in = {s3_sign_ff, 63'd0};
            end
         end
         default: dbl_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) s4_dbl_ff <= dbl_in;
   end

   // stage 5: round to unsigned integer, half away from zero
   logic [10:0]  e4;
   logic [52:0]  sig;
   logic [5:0]   ush;
   logic [53:0]  rsh;
   logic [32:0]  tsum;
   logic [31:0]  uint_in;
   logic [63:0]  dbl5_ff;
   logic [31:0]  uint5_ff;

   always_comb begin
      e4   = s4_dbl_ff[62:52];
      sig  = {1'b1, s4_dbl_ff[51:0]};
      ush  = 6'(11'd1075 - e4 - 11'd1);
      rsh  = {1'b0, sig} >> ush;
      tsum = 33'(rsh[53:1]) + 33'(rsh[0]);
      if (s4_dbl_ff[63] || e4 < 11'd1022) begin
         uint_in = '0;
      end else if (e4 == 11'h7FF) begin
         uint_in = (s4_dbl_ff[51:0] != '0) ? 32'd0 : U32_MAX;
      end else if (e4 >= 11'd1055 || tsum[32]) begin
         uint_in = U32_MAX;
      end else begin
         uint_in = tsum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         dbl5_ff  <= s4_dbl_ff;
         uint5_ff <= uint_in;
      end
   end

   assign rsp_valid            = v5_ff;
   assign rsp_double_bits      = dbl5_ff;
   assign rsp_rounded_unsigned = uint5_ff;

`ifndef ASSERT_OFF
   a_neg_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_double_bits[63] |-> rsp_rounded_unsigned == 32'd0)
      else $error("negative value gave nonzero integer");
   a_nan_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_double_bits[62:52] == 11'h7FF && rsp_double_bits[51:0] != '0
      |-> rsp_double_bits == DBL_QNAN)
      else $error("NaN is not the default quiet NaN");
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");
`endif

endmodule
